FILE: rtl/core/pfa_pkg.sv
// ============================================================================
// pfa_pkg
// Shared types and constants of the page frame allocator: action and status
// codes, controller states, register map and the memory control group.
// ============================================================================
`default_nettype none

package pfa_pkg;

    localparam int AddrW     = 24;   // linear byte address width
    localparam int CfgW      = 25;   // configuration register width
    localparam int CountW    = 8;    // use count width
    localparam int FrameShift = 12;  // 4096-byte frames
    localparam int PaddrW    = 3;    // two 32-bit registers
    localparam int PdataW    = 32;

    localparam logic [CountW-1:0] ReservedCount = 8'd100;
    localparam logic [CountW-1:0] UsedCount     = 8'd1;

    localparam logic [CfgW-1:0] StartReset = 25'd1048576;
    localparam logic [CfgW-1:0] EndReset   = 25'd16777216;

    // Register select is the word address bit of paddr.
    localparam logic RegStart = 1'b0;
    localparam logic RegEnd   = 1'b1;

    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_FREE      = 3'd1,
        ST_BELOW_LOW    = 3'd2,
        ST_BEYOND_END   = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT_PREP,
        S_INIT,
        S_ALLOC,
        S_FREE_CHECK,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_ram_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/page_frame_allocator.sv
// ============================================================================
// page_frame_allocator
// Reference-counted page frame allocator with one 8-bit use count per frame,
// kept in a single synchronous memory.
// ============================================================================
//
//   Channel   Direction  Handshake            Payload
//   -------   ---------  -------------------  ------------------------------
//   request   in         i_valid / o_stall    i_action, i_address
//   result    out        o_valid / i_stall    o_frame_address, o_status
//   config    in         APB-style, psel...   start_address, end_address
//
// A free reads the count of its frame unless the address alone decides it, and
// the unused action goes straight to its result. An init and an allocation
// walk the count memory one entry per cycle. After reset a clearing pass
// writes the reserved count into all FRAME_COUNT entries, one per cycle,
// with o_stall high until it is done. A stalled result waits in the output
// register while the next item is taken and worked on.
`default_nettype none

module page_frame_allocator #(
    parameter int FRAME_COUNT  = 3840,
    parameter int LOW_BOUNDARY = 1048576
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request item
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [1:0]                  i_action,
    input  wire logic [pfa_pkg::AddrW-1:0]   i_address,
    // result item
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [pfa_pkg::AddrW-1:0]        o_frame_address,
    output logic [2:0]                       o_status,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pfa_pkg::PaddrW-1:0]  paddr,
    input  wire logic [pfa_pkg::PdataW-1:0]  pwdata,
    output logic [pfa_pkg::PdataW-1:0]       prdata,
    output logic                             pready
);

    // Frame index width, and a wider width for range compares that must be
    // able to hold FRAME_COUNT itself and the sum first + n of an init.
    localparam int AW = $clog2(FRAME_COUNT);
    localparam int RW = ((AW > 14) ? AW : 14) + 1;

    localparam logic [AW-1:0] LastIdx = AW'(FRAME_COUNT - 1);
    localparam logic [RW-1:0] FcR     = RW'(FRAME_COUNT);
    localparam logic [pfa_pkg::CfgW-1:0] LowB = pfa_pkg::CfgW'(LOW_BOUNDARY);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pfa_pkg::CfgW-1:0] cfg_start;
    logic [pfa_pkg::CfgW-1:0] cfg_end;

    pfa_cfg_regs u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_start_address (cfg_start),
        .o_end_address   (cfg_end)
    );

    // ------------------------------------------------------------------
    // Use count memory
    // ------------------------------------------------------------------
    pfa_pkg::t_ram_ctl           ram_ctl;
    logic [AW-1:0]               ram_wr_addr;
    logic [pfa_pkg::CountW-1:0]  ram_wr_data;
    logic [AW-1:0]               ram_rd_addr;
    logic [pfa_pkg::CountW-1:0]  ram_rd_data;

    pfa_count_ram #(
        .DEPTH (FRAME_COUNT),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_ctl     (ram_ctl),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Controller registers
    // ------------------------------------------------------------------
    pfa_pkg::t_state             r_state,      n_state;
    logic [AW-1:0]               r_k,          n_k;          // sweep / scan index
    logic [AW-1:0]               r_chk_idx,    n_chk_idx;    // entry whose data returns
    logic                        r_chk_pend,   n_chk_pend;
    logic                        r_more,       n_more;       // scan reads still to issue
    logic [RW-1:0]               r_first,      n_first;      // init clear range
    logic [RW-1:0]               r_last,       n_last;
    logic [pfa_pkg::AddrW-1:0]   r_res_addr,   n_res_addr;
    pfa_pkg::t_status            r_res_status, n_res_status;
    logic                        r_out_valid,  n_out_valid;
    logic [pfa_pkg::AddrW-1:0]   r_out_addr,   n_out_addr;
    pfa_pkg::t_status            r_out_status, n_out_status;

    // Free address decode, taken straight from the request port.
    logic [pfa_pkg::CfgW-1:0] free_addr;
    logic [pfa_pkg::CfgW-1:0] free_diff;
    logic [RW-1:0]            free_idx;

    assign free_addr = pfa_pkg::CfgW'(i_address);
    assign free_diff = free_addr - LowB;
    assign free_idx  = RW'(free_diff[pfa_pkg::AddrW-1:pfa_pkg::FrameShift]);

    // Init range from the configuration registers.
    logic [pfa_pkg::CfgW-1:0] init_start;
    logic [pfa_pkg::CfgW-1:0] init_off;
    logic [pfa_pkg::CfgW-1:0] init_len;

    assign init_start = (cfg_start < LowB) ? LowB : cfg_start;
    assign init_off   = init_start - LowB;
    assign init_len   = cfg_end - init_start;

    // Address of the frame found by the allocation scan.
    logic [pfa_pkg::AddrW-1:0] alloc_addr;
    assign alloc_addr = LowB[pfa_pkg::AddrW-1:0]
                      + pfa_pkg::AddrW'({r_chk_idx, {pfa_pkg::FrameShift{1'b0}}});

    logic [RW-1:0] sweep_k;
    assign sweep_k = RW'(r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfa_pkg::S_CLEAR;
            r_k         <= '0;
            r_chk_pend  <= 1'b0;
            r_more      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_chk_pend  <= n_chk_pend;
            r_more      <= n_more;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx    <= n_chk_idx;
        r_first      <= n_first;
        r_last       <= n_last;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_chk_idx    = r_chk_idx;
        n_chk_pend   = r_chk_pend;
        n_more       = r_more;
        n_first      = r_first;
        n_last       = r_last;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;

        ram_ctl     = '0;
        ram_wr_addr = r_k;
        ram_wr_data = pfa_pkg::ReservedCount;
        ram_rd_addr = r_k;

        // The output register empties when its item is taken.
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            pfa_pkg::S_CLEAR: begin
                // Post-reset pass: every entry starts out reserved.
                ram_ctl.we = 1'b1;
                if (r_k == LastIdx) begin
                    n_k     = '0;
                    n_state = pfa_pkg::S_IDLE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end

            pfa_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_res_addr   = '0;
                    n_res_status = pfa_pkg::ST_OK;
                    case (pfa_pkg::t_action'(i_action))
                        pfa_pkg::ACT_INIT: begin
                            n_state = pfa_pkg::S_INIT_PREP;
                        end
                        pfa_pkg::ACT_ALLOC: begin
                            n_k        = LastIdx;
                            n_more     = 1'b1;
                            n_chk_pend = 1'b0;
                            n_state    = pfa_pkg::S_ALLOC;
                        end
                        pfa_pkg::ACT_FREE: begin
                            if (free_addr < LowB) begin
                                n_res_status = pfa_pkg::ST_BELOW_LOW;
                                n_state      = pfa_pkg::S_RESULT;
                            end else if (free_addr >= cfg_end || free_idx >= FcR) begin
                                n_res_status = pfa_pkg::ST_BEYOND_END;
                                n_state      = pfa_pkg::S_RESULT;
                            end else begin
                                ram_ctl.re  = 1'b1;
                                ram_rd_addr = free_idx[AW-1:0];
                                n_chk_idx   = free_idx[AW-1:0];
                                n_state     = pfa_pkg::S_FREE_CHECK;
                            end
                        end
                        default: begin
                            n_state = pfa_pkg::S_RESULT;
                        end
                    endcase
                end
            end

            pfa_pkg::S_INIT_PREP: begin
                // An empty range when the end does not lie above the start.
                if (cfg_end <= init_start) begin
                    n_first = '0;
                    n_last  = '0;
                end else begin
                    n_first = RW'(init_off[pfa_pkg::CfgW-1:pfa_pkg::FrameShift]);
                    n_last  = RW'(init_off[pfa_pkg::CfgW-1:pfa_pkg::FrameShift])
                            + RW'(init_len[pfa_pkg::CfgW-1:pfa_pkg::FrameShift]);
                end
                n_k     = '0;
                n_state = pfa_pkg::S_INIT;
            end

            pfa_pkg::S_INIT: begin
                ram_ctl.we = 1'b1;
                if (sweep_k >= r_first && sweep_k < r_last) begin
                    ram_wr_data = '0;
                end
                if (r_k == LastIdx) begin
                    n_k     = '0;
                    n_state = pfa_pkg::S_RESULT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end

            pfa_pkg::S_ALLOC: begin
                // Reads run one entry ahead of the check of returned data.
                ram_ctl.re = r_more;
                if (r_chk_pend && ram_rd_data == '0) begin
                    ram_ctl.we   = 1'b1;
                    ram_wr_addr  = r_chk_idx;
                    ram_wr_data  = pfa_pkg::UsedCount;
                    n_res_addr   = alloc_addr;
                    n_res_status = pfa_pkg::ST_OK;
                    n_chk_pend   = 1'b0;
                    n_more       = 1'b0;
                    n_state      = pfa_pkg::S_RESULT;
                end else if (r_chk_pend && r_chk_idx == '0) begin
                    n_res_addr   = '0;
                    n_res_status = pfa_pkg::ST_NO_FREE;
                    n_chk_pend   = 1'b0;
                    n_more       = 1'b0;
                    n_state      = pfa_pkg::S_RESULT;
                end else begin
                    n_chk_pend = r_more;
                    n_chk_idx  = r_k;
                    if (r_more) begin
                        if (r_k == '0) begin
                            n_more = 1'b0;
                        end else begin
                            n_k = r_k - 1'b1;
                        end
                    end
                end
            end

            pfa_pkg::S_FREE_CHECK: begin
                if (ram_rd_data == '0) begin
                    n_res_status = pfa_pkg::ST_ALREADY_FREE;
                end else begin
                    ram_ctl.we   = 1'b1;
                    ram_wr_addr  = r_chk_idx;
                    ram_wr_data  = ram_rd_data - 1'b1;
                    n_res_status = pfa_pkg::ST_OK;
                end
                n_state = pfa_pkg::S_RESULT;
            end

            pfa_pkg::S_RESULT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_state      = pfa_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = pfa_pkg::S_IDLE;
            end
        endcase
    end

    assign o_stall         = (r_state != pfa_pkg::S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_frame_address = r_out_addr;
    assign o_status        = r_out_status;

endmodule

`default_nettype wire

FILE: rtl/core/pfa_count_ram.sv
// ============================================================================
// pfa_count_ram
// Use count memory: one write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module pfa_count_ram #(
    parameter int DEPTH = 3840,
    parameter int AW    = 12
) (
    input  wire logic                       i_clk,
    input  wire pfa_pkg::t_ram_ctl          i_ctl,
    input  wire logic [AW-1:0]              i_wr_addr,
    input  wire logic [pfa_pkg::CountW-1:0] i_wr_data,
    input  wire logic [AW-1:0]              i_rd_addr,
    output logic [pfa_pkg::CountW-1:0]      o_rd_data
);

    logic [pfa_pkg::CountW-1:0] r_mem [DEPTH];
    logic [pfa_pkg::CountW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/core/pfa_cfg_regs.sv
// ============================================================================
// pfa_cfg_regs
// APB-style register file holding the start and end addresses.
// ============================================================================
`default_nettype none

module pfa_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pfa_pkg::PaddrW-1:0]  paddr,
    input  wire logic [pfa_pkg::PdataW-1:0]  pwdata,
    output logic [pfa_pkg::PdataW-1:0]       prdata,
    output logic                             pready,
    output logic [pfa_pkg::CfgW-1:0]         o_start_address,
    output logic [pfa_pkg::CfgW-1:0]         o_end_address
);

    logic [pfa_pkg::CfgW-1:0] r_start;
    logic [pfa_pkg::CfgW-1:0] r_end;
    logic                     wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= pfa_pkg::StartReset;
            r_end   <= pfa_pkg::EndReset;
        end else if (wr_hit) begin
            if (paddr[2] == pfa_pkg::RegStart) begin
                r_start <= pwdata[pfa_pkg::CfgW-1:0];
            end else begin
                r_end <= pwdata[pfa_pkg::CfgW-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == pfa_pkg::RegEnd) begin
            prdata = pfa_pkg::PdataW'(r_end);
        end else begin
            prdata = pfa_pkg::PdataW'(r_start);
        end
    end

    assign o_start_address = r_start;
    assign o_end_address   = r_end;

endmodule

`default_nettype wire

FILE: rtl/core/pfa_checker.sv
// ============================================================================
// pfa_checker
// Port-level checks of the page frame allocator, bound to the top level.
// ============================================================================
`default_nettype none

module pfa_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_stall,
    input wire logic                       o_valid,
    input wire logic                       i_stall,
    input wire logic [pfa_pkg::AddrW-1:0]  o_frame_address,
    input wire logic [2:0]                 o_status
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result item dropped while stalled");

    // Only a successful allocation carries an address.
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != pfa_pkg::ST_OK |-> o_frame_address == '0)
        else $error("frame address on a failed item");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= pfa_pkg::ST_ALREADY_FREE)
        else $error("undefined status code");

    // Reset empties the output and starts the clearing pass.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("reset did not clear output or start clearing pass");

    // No new item enters until the previous result has been loaded.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("item accepted while another is in work");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_frame_address (o_frame_address),
    .o_status        (o_status)
);

`default_nettype wire
